// File: src/avu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avu_pkg
// Shared types and constants for the angle unwrap and velocity estimator.
// ----------------------------------------------------------------------------
package avu_pkg;

  // Raw sensor angle bits kept for unwrapping
  localparam int unsigned CountBits = 24;

  // Field widths
  localparam int unsigned AngleW  = 25;  // sample_angle, signed
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CprW    = 25;
  localparam int unsigned MinW    = 20;
  localparam int unsigned CfgW    = 25;
  localparam int unsigned WordW   = 32;

  // Stream payload widths
  localparam int unsigned InDataW  = 64;  // 57 used bits, padded to bytes
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 96;
  localparam int unsigned OutUserW = 2;

  // Signed step during unwrap: raw difference plus or minus one revolution
  localparam int unsigned DiffW = ((CountBits > CprW) ? CountBits : CprW) + 2;

  // Velocity scale: 2*pi * 1e6 * 2^16, rounded
  localparam logic [38:0] VelK = 39'd411774832291;
  localparam int unsigned ProdW = 70;   // |delta| <= 2^31 times VelK
  localparam int unsigned DsrW  = 57;   // elapsed (32b) times counts_per_rev

  // Item kinds
  typedef enum logic [1:0] {
    CmdSample   = 2'd0,
    CmdVelocity = 2'd1,
    CmdSeed     = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic CfgCountsPerRev = 1'b0;
  localparam logic CfgMinElapsed   = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StExec,
    StMul0,
    StMul1,
    StMul2,
    StVelChk,
    StVelDiv,
    StVelFin,
    StRotStart,
    StRotWait,
    StDone
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DsrW-1:0]   rem_init;
    logic [WordW-1:0]  dividend;
    logic [DsrW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WordW-1:0]  quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: src/avu_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avu_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module avu_mul (
  input  wire logic                          clk_i,
  input  wire logic [avu_pkg::WordW-1:0]     a_i,
  input  wire logic [avu_pkg::WordW-1:0]     b_i,
  output logic      [2*avu_pkg::WordW-1:0]   p_o
);
  import avu_pkg::*;

  logic [2*WordW-1:0] p_q;

  // one product per cycle, available the cycle after the operands
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: src/avu_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avu_divider
// Restoring shift-subtract divider, one quotient bit per cycle, 32 steps.
// The partial remainder starts from rem_init, which must be below divisor.
// ----------------------------------------------------------------------------
module avu_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire avu_pkg::div_req_t  req_i,
  output avu_pkg::div_rsp_t       rsp_o
);
  import avu_pkg::*;

  localparam int unsigned CntW = $clog2(WordW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DsrW-1:0] rem_q, dsr_q;
  logic [WordW-1:0] dvd_q, quo_q;

  logic [DsrW:0]   trial;
  logic [DsrW:0]   sub;
  logic            ge;

  // one trial subtraction per step
  assign trial = {rem_q, dvd_q[WordW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign sub   = trial - {1'b0, dsr_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(WordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? sub[DsrW-1:0] : trial[DsrW-1:0];
      dvd_q <= {dvd_q[WordW-2:0], 1'b0};
      quo_q <= {quo_q[WordW-2:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

// File: src/angle_unwrap_velocity_estimator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// angle_unwrap_velocity_estimator_unit
// Angle unwrapper and velocity estimator for an integer-count position sensor.
// ----------------------------------------------------------------------------
// Each input beat is a sample (raw angle and microsecond timestamp), a
// velocity request or a reference seed. Each produces exactly one result beat
// with the unwrapped angle, the full rotation count, the velocity in rad/s
// (signed Q16.16, saturated) and two flags. The block takes one beat at a time.
// A sample, a seed, the unused kind or a velocity request that holds presents
// its result after one 32-step pass through the shared divider that forms the
// rotation count. A velocity request that recomputes adds, before that pass,
// the states StMul0 to StMul2 on the shared multiplier, a range check, a
// second 32-step pass through the same divider and a commit. A quotient too
// wide for 32 bits saturates and skips the second pass. With counts per
// revolution of zero the rotation divide is skipped. A new beat is taken
// while the previous result still waits in the output register. A finished
// result that finds that register still full waits, and the input stays
// stalled until the register is read. Configuration is written through
// cfg_we_i/cfg_index_i/cfg_data_i while idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module angle_unwrap_velocity_estimator_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_index_i,
  input  wire logic [avu_pkg::CfgW-1:0]       cfg_data_i,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [24:0] sample_angle, [56:25] timestamp_us, [63:57] zero
  input  wire logic [avu_pkg::InDataW-1:0]    s_axis_tdata,
  // [1:0] command
  input  wire logic [avu_pkg::InUserW-1:0]    s_axis_tuser,
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [31:0] accumulated_angle, [63:32] rotation_count, [95:64] velocity_q16
  output logic      [avu_pkg::OutDataW-1:0]   m_axis_tdata,
  // [0] velocity_updated, [1] sample_rejected
  output logic      [avu_pkg::OutUserW-1:0]   m_axis_tuser
);
  import avu_pkg::*;

  state_e state_q, state_d;

  // configuration
  logic [CprW-1:0] cpr_q;
  logic [MinW-1:0] min_q;

  // block state
  logic [CountBits-1:0] last_raw_q;
  logic [WordW-1:0]     accum_q, sample_time_q, ref_angle_q, ref_time_q, vel_q;

  // item and working registers
  logic [1:0]        cmd_q;
  logic [AngleW-1:0] ang_q;
  logic [TimeW-1:0]  ts_q;
  logic [WordW-1:0]  mag_q, vq_q, rot_q;
  logic              neg_q, rot_neg_q;
  logic [ProdW-1:0]  prod_q;
  logic              updated_q, rejected_q;

  // output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;

  logic in_fire, out_free;

  // shared units
  logic [WordW-1:0]   mul_a, mul_b;
  logic [2*WordW-1:0] mul_p;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  avu_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  avu_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // unwrap step
  logic [CountBits-1:0]  raw;
  logic                  ang_neg;
  logic signed [DiffW-1:0] diff, diff_mag, cpr_s, half_s, step;

  assign raw      = ang_q[CountBits-1:0];
  assign ang_neg  = ang_q[AngleW-1];
  assign diff     = $signed({{(DiffW-CountBits){1'b0}}, raw})
                  - $signed({{(DiffW-CountBits){1'b0}}, last_raw_q});
  assign diff_mag = diff[DiffW-1] ? -diff : diff;
  assign cpr_s    = $signed({{(DiffW-CprW){1'b0}}, cpr_q});
  assign half_s   = $signed({{(DiffW-CprW+1){1'b0}}, cpr_q[CprW-1:1]});

  always_comb begin
    step = diff;
    if (diff_mag > half_s) begin
      step = diff[DiffW-1] ? diff + cpr_s : diff - cpr_s;
    end
  end

  // velocity preconditions
  logic [WordW-1:0] elapsed, delta, accum_mag;
  logic             vel_ok;
  logic             big;
  logic [DsrW-1:0]  divisor;

  assign elapsed   = sample_time_q - ref_time_q;
  assign delta     = accum_q - ref_angle_q;
  assign vel_ok    = (elapsed != '0) && (elapsed >= {{(WordW-MinW){1'b0}}, min_q})
                   && (cpr_q != '0);
  assign accum_mag = accum_q[WordW-1] ? (~accum_q + 1'b1) : accum_q;
  assign divisor   = mul_p[DsrW-1:0];
  assign big       = {{(DsrW-(ProdW-WordW)){1'b0}}, prod_q[ProdW-1:WordW]} >= divisor;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:     if (s_axis_tvalid) state_d = StExec;
      StExec:     state_d = (cmd_q == CmdVelocity && vel_ok) ? StMul0 : StRotStart;
      StMul0:     state_d = StMul1;
      StMul1:     state_d = StMul2;
      StMul2:     state_d = StVelChk;
      StVelChk:   state_d = big ? StVelFin : StVelDiv;
      StVelDiv:   if (div_rsp.done) state_d = StVelFin;
      StVelFin:   state_d = StRotStart;
      StRotStart: state_d = (cpr_q == '0) ? StDone : StRotWait;
      StRotWait:  if (div_rsp.done) state_d = StDone;
      StDone:     if (out_free) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready    = 1'b0;
    mul_a            = mag_q;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.rem_init = '0;
    div_req.dividend = accum_mag;
    div_req.divisor  = {{(DsrW-CprW){1'b0}}, cpr_q};
    unique case (state_q)
      StIdle: s_axis_tready = 1'b1;
      StMul0: mul_b = VelK[WordW-1:0];
      StMul1: mul_b = {{(2*WordW-$bits(VelK)){1'b0}}, VelK[$bits(VelK)-1:WordW]};
      StMul2: begin
        mul_a = elapsed;
        mul_b = {{(WordW-CprW){1'b0}}, cpr_q};
      end
      StVelChk: begin
        div_req.start    = !big;
        div_req.rem_init = {{(DsrW-(ProdW-WordW)){1'b0}}, prod_q[ProdW-1:WordW]};
        div_req.dividend = prod_q[WordW-1:0];
        div_req.divisor  = divisor;
      end
      StRotStart: div_req.start = (cpr_q != '0);
      default: ;
    endcase
  end

  // state register, configuration and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      cpr_q         <= CprW'(4096);
      min_q         <= MinW'(100);
      last_raw_q    <= '0;
      accum_q       <= '0;
      sample_time_q <= '0;
      ref_angle_q   <= '0;
      ref_time_q    <= '0;
      vel_q         <= '0;
      updated_q     <= 1'b0;
      rejected_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgCountsPerRev: cpr_q <= cfg_data_i[CprW-1:0];
          CfgMinElapsed:   min_q <= cfg_data_i[MinW-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        updated_q  <= 1'b0;
        rejected_q <= 1'b0;
      end

      // sample and seed updates
      if (state_q == StExec) begin
        case (cmd_q)
          CmdSample: begin
            if (ang_neg) begin
              rejected_q <= 1'b1;
            end else begin
              accum_q       <= accum_q + {{(WordW-DiffW){step[DiffW-1]}}, step};
              last_raw_q    <= raw;
              sample_time_q <= ts_q;
            end
          end
          CmdSeed: begin
            if (ang_neg) begin
              rejected_q <= 1'b1;
            end else begin
              last_raw_q    <= raw;
              accum_q       <= {{(WordW-CountBits){1'b0}}, raw};
              ref_angle_q   <= {{(WordW-CountBits){1'b0}}, raw};
              sample_time_q <= ts_q;
              ref_time_q    <= ts_q;
            end
          end
          default: ;
        endcase
      end

      // velocity commit with saturation
      if (state_q == StVelFin) begin
        if (neg_q) begin
          vel_q <= '0 - vq_q;
        end else begin
          vel_q <= vq_q[WordW-1] ? {1'b0, {(WordW-1){1'b1}}} : vq_q;
        end
        ref_angle_q <= accum_q;
        ref_time_q  <= sample_time_q;
        updated_q   <= 1'b1;
      end

      // output register
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= s_axis_tuser;
      ang_q <= s_axis_tdata[AngleW-1:0];
      ts_q  <= s_axis_tdata[AngleW +: TimeW];
    end

    unique case (state_q)
      StExec: begin
        neg_q <= delta[WordW-1];
        mag_q <= delta[WordW-1] ? (~delta + 1'b1) : delta;
      end
      StMul1: prod_q <= {{(ProdW-2*WordW){1'b0}}, mul_p};
      StMul2: prod_q <= prod_q + {mul_p[ProdW-WordW-1:0], {WordW{1'b0}}};
      StVelChk: if (big) vq_q <= {1'b1, {(WordW-1){1'b0}}};
      StVelDiv: begin
        if (div_rsp.done) begin
          vq_q <= (div_rsp.quotient > {1'b1, {(WordW-1){1'b0}}})
                ? {1'b1, {(WordW-1){1'b0}}} : div_rsp.quotient;
        end
      end
      StRotStart: begin
        rot_neg_q <= accum_q[WordW-1];
        rot_q     <= '0;
      end
      StRotWait: begin
        if (div_rsp.done) begin
          rot_q <= rot_neg_q ? ('0 - div_rsp.quotient) : div_rsp.quotient;
        end
      end
      StDone: begin
        if (out_free) begin
          out_data_q <= {vel_q, rot_q, accum_q};
          out_user_q <= {rejected_q, updated_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire

// File: sim/tb_angle_unwrap_velocity_estimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_angle_unwrap_velocity_estimator_unit
// Self-checking bench for the angle unwrap and velocity estimator.
// ----------------------------------------------------------------------------
// A model of the unwrap and velocity math predicts one result per accepted
// input beat. Each result beat is compared field by field against the oldest
// prediction. The stimulus opens with a directed run: error angles, folds,
// exact half-revolution steps, saturation both ways, timestamp wrap and the
// unused kind. Random phases follow under several register settings, the
// extremes among them. Most of each phase is seeded tracks of samples and
// velocity requests, mixed with noise and rejected angles. Both stream sides
// idle at random, and the output side holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_angle_unwrap_velocity_estimator_unit;
  import avu_pkg::*;

  localparam logic [63:0] VelScale   = 64'd411774832291;  // 2*pi * 1e6 * 2^16
  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned TailCycles = 100;
  localparam int unsigned LongHold   = 400;

  // One predicted result beat
  typedef struct {
    logic [31:0] accum;
    logic [31:0] rotations;
    logic [31:0] velocity;
    logic        updated;
    logic        rejected;
  } motion_report_t;

  // Predicts the block's state and holds results not yet seen
  class motion_model;
    logic [24:0]    counts_per_rev;
    logic [19:0]    min_elapsed;
    logic [23:0]    last_raw;
    logic [31:0]    accum;
    logic [31:0]    sample_ts;
    logic [31:0]    ref_accum;
    logic [31:0]    ref_ts;
    logic [31:0]    velocity;
    motion_report_t due_reports[$];
    int unsigned    mismatches;

    function new();
      counts_per_rev = 25'd4096;
      min_elapsed    = 20'd100;
      last_raw       = '0;
      accum          = '0;
      sample_ts      = '0;
      ref_accum      = '0;
      ref_ts         = '0;
      velocity       = '0;
      mismatches     = 0;
    endfunction

    function void set_register(logic idx, logic [24:0] value);
      if (idx == CfgCountsPerRev) begin
        counts_per_rev = value;
      end else begin
        min_elapsed = value[19:0];
      end
    endfunction

    // Apply one accepted input beat and queue the result it should produce
    function void take_item(logic [1:0] cmd, logic [24:0] angle, logic [31:0] ts);
      motion_report_t    rep;
      logic [23:0]       raw;
      longint            step;
      longint            jump;
      logic [31:0]       span;
      logic signed [31:0] delta;
      logic signed [31:0] acc_s;
      logic [63:0]       mag;
      logic [127:0]      quo;
      raw          = angle[23:0];
      rep.updated  = 1'b0;
      rep.rejected = 1'b0;
      case (cmd)
        CmdSample: begin
          if (angle[24]) begin
            rep.rejected = 1'b1;
          end else begin
            // fold steps beyond half a revolution
            step = longint'(raw) - longint'(last_raw);
            jump = (step < 0) ? -step : step;
            if (jump > longint'(counts_per_rev >> 1)) begin
              step += (step > 0) ? -longint'(counts_per_rev) : longint'(counts_per_rev);
            end
            accum     = accum + step[31:0];
            last_raw  = raw;
            sample_ts = ts;
          end
        end
        CmdVelocity: begin
          span = sample_ts - ref_ts;
          if (span != 0 && span >= 32'(min_elapsed) && counts_per_rev != 0) begin
            delta = accum - ref_accum;
            step  = longint'(delta);
            mag   = (step < 0) ? 64'(-step) : 64'(step);
            quo   = (128'(mag) * 128'(VelScale)) / (128'(span) * 128'(counts_per_rev));
            if (quo > 128'h8000_0000) quo = 128'h8000_0000;
            if (delta < 0) begin
              velocity = 32'd0 - quo[31:0];
            end else begin
              velocity = (quo >= 128'h8000_0000) ? 32'h7FFF_FFFF : quo[31:0];
            end
            ref_accum   = accum;
            ref_ts      = sample_ts;
            rep.updated = 1'b1;
          end
        end
        CmdSeed: begin
          if (angle[24]) begin
            rep.rejected = 1'b1;
          end else begin
            last_raw  = raw;
            accum     = {8'd0, raw};
            ref_accum = {8'd0, raw};
            sample_ts = ts;
            ref_ts    = ts;
          end
        end
        default: ;
      endcase
      rep.accum    = accum;
      rep.velocity = velocity;
      if (counts_per_rev == 0) begin
        rep.rotations = '0;
      end else begin
        acc_s         = accum;
        rep.rotations = 32'(longint'(acc_s) / longint'(counts_per_rev));
      end
      due_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Check one accepted result beat against the oldest prediction
    function void check_beat(logic [OutDataW-1:0] data, logic [OutUserW-1:0] user);
      motion_report_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, expected none, actual %h / %b",
                 $time, data, user);
        return;
      end
      want = due_reports.pop_front();
      compare_field("accumulated_angle", want.accum, data[31:0]);
      compare_field("rotation_count", want.rotations, data[63:32]);
      compare_field("velocity_q16", want.velocity, data[95:64]);
      compare_field("velocity_updated", 32'(want.updated), 32'(user[0]));
      compare_field("sample_rejected", 32'(want.rejected), 32'(user[1]));
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic                 cfg_index_i   = 1'b0;
  logic [CfgW-1:0]      cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [InUserW-1:0]   s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [OutUserW-1:0]  m_axis_tuser;

  motion_model  sb = new();
  int unsigned  items_sent = 0;
  bit           send_idle  = 1'b1;
  logic [24:0]  cur_cpr    = 25'd4096;
  logic [19:0]  cur_min    = 20'd100;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  angle_unwrap_velocity_estimator_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Offer one input beat, optionally after a random gap, and wait for accept
  task automatic send_item(logic [1:0] cmd, logic [24:0] angle, logic [31:0] ts);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ts, angle};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_item(cmd, angle, ts);
    items_sent++;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait until every predicted result has been seen
  task automatic drain();
    while (sb.due_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_registers(logic [24:0] cpr, logic [19:0] min_us);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgCountsPerRev;
    cfg_data_i  <= cpr;
    @(posedge clk_i);
    cfg_index_i <= CfgMinElapsed;
    cfg_data_i  <= 25'(min_us);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(CfgCountsPerRev, cpr);
    sb.set_register(CfgMinElapsed, 25'(min_us));
    cur_cpr = cpr;
    cur_min = min_us;
  endtask

  // Angle step: half within half a revolution, some folding, some anywhere
  function automatic longint pick_step();
    longint      lim;
    int unsigned kind;
    lim  = (cur_cpr == 0) ? 1000 : longint'(cur_cpr);
    kind = $urandom_range(0, 9);
    if (kind >= 8) return longint'($urandom_range(0, 32'hFF_FFFF));
    if (kind < 5) lim = lim / 2;
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  // Seeded track: samples moving in time with velocity requests between
  task automatic run_track(int unsigned len);
    logic [23:0] pos;
    logic [31:0] t;
    longint      step;
    pos = 24'($urandom);
    t   = $urandom;
    send_item(CmdSeed, {1'b0, pos}, t);
    repeat (len) begin
      case ($urandom_range(0, 11))
        0, 1, 2: send_item(CmdVelocity, 25'($urandom), $urandom);
        3:       send_item(CmdSample, {1'b1, 24'($urandom)}, $urandom);
        default: begin
          step = pick_step();
          pos  = pos + step[23:0];
          if ($urandom_range(0, 9) == 0) begin
            t = t + $urandom;
          end else begin
            t = t + $urandom_range(0, 32'(cur_min) / 2 + 4);
          end
          send_item(CmdSample, {1'b0, pos}, t);
        end
      endcase
    end
  endtask

  task automatic run_phase(logic [24:0] cpr, logic [19:0] min_us, int unsigned count);
    int unsigned goal;
    stop_sending();
    drain();
    program_registers(cpr, min_us);
    goal = items_sent + count;
    while (items_sent < goal) begin
      send_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 8) begin
        send_item(2'($urandom_range(0, 3)), 25'($urandom), $urandom);
      end else begin
        run_track($urandom_range(3, 16));
      end
    end
  endtask

  // Directed opening under the reset settings
  task automatic run_directed();
    send_item(CmdVelocity, 25'd0, 32'd0);          // zero elapsed after reset
    send_item(CmdSample, 25'd0, 32'd0);
    send_item(CmdSample, 25'h0FF_FFFF, 32'hFFFF_FFFF);
    send_item(CmdSample, 25'h1FF_FFFF, 32'd5);     // error angle -1
    send_item(CmdSample, 25'h100_0000, 32'd6);     // most negative angle
    send_item(CmdSeed, 25'h180_0000, 32'd7);       // rejected seed
    send_item(CmdUnused, 25'h0AB_CDEF, 32'h1234_5678);
    send_item(CmdSeed, 25'd1000, 32'd1000);
    send_item(CmdSample, 25'd1100, 32'd1050);
    send_item(CmdVelocity, 25'd0, 32'd0);          // elapsed below minimum
    send_item(CmdSample, 25'd1300, 32'd1100);
    send_item(CmdVelocity, 25'd0, 32'd0);          // elapsed exactly at minimum
    send_item(CmdSample, 25'd3300, 32'd1150);
    send_item(CmdSample, 25'd5300, 32'd1200);
    send_item(CmdVelocity, 25'h1FF_FFFF, 32'hFFFF_FFFF);  // positive saturation
    send_item(CmdSample, 25'd3252, 32'd1250);      // step of exactly half, no fold
    send_item(CmdSample, 25'd1204, 32'd1300);
    send_item(CmdVelocity, 25'd0, 32'd0);          // negative saturation
    send_item(CmdSample, 25'd3253, 32'd1350);      // just past half, folds
    send_item(CmdSample, 25'd10, 32'd1400);        // large negative step, folds up
    send_item(CmdSeed, 25'd5, 32'hFFFF_FFC0);
    send_item(CmdSample, 25'd7, 32'h0000_0040);    // timestamp wraps
    send_item(CmdVelocity, 25'd0, 32'd0);
    send_item(CmdVelocity, 25'd0, 32'd0);          // zero elapsed again
    send_item(CmdUnused, 25'd0, 32'd0);
  endtask

  // Result side: random ready gaps plus long hold-offs
  initial begin : result_sink
    int unsigned beats;
    int unsigned gap;
    bit          idle_on;
    beats   = 0;
    idle_on = 1'b1;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (beats % 50 == 0) idle_on = $urandom_range(0, 1);
      if (beats == 300 || beats == 1100) begin
        gap = LongHold;
      end else begin
        gap = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_beat(m_axis_tdata, m_axis_tuser);
      beats++;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** angle_unwrap_velocity_estimator_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    program_registers(25'd4096, 20'd100);
    run_directed();

    run_phase(25'd2, 20'd0, 200);
    run_phase(25'd16777216, 20'd1000000, 200);
    run_phase(25'd1, 20'd3, 180);
    run_phase(25'd0, 20'd50, 150);
    run_phase(25'd360, 20'd1, 200);
    run_phase(25'd4096, 20'd100, 200);
    run_phase(25'($urandom_range(2, 16777216)), 20'($urandom_range(0, 2000)), 160);
    run_phase(25'd65536, 20'd200, 200);
    run_phase(25'd33554431, 20'd1048575, 140);   // all-ones register values

    stop_sending();
    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.due_reports.size() != 0) begin
      sb.mismatches++;
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, sb.due_reports.size());
    end
    if (sb.mismatches == 0) begin
      $display("** angle_unwrap_velocity_estimator_unit: PASSED **");
    end else begin
      $display("** angle_unwrap_velocity_estimator_unit: FAILED **");
    end
    $finish;
  end

endmodule
